// ===== hdl/vmix_pkg.sv =====
// Package with constants, request codes and helper types for the voice mixer.
package vmix_pkg;

	localparam int VOICES_DEF       = 8;
	localparam int SAMPLE_DEPTH_DEF = 65536;

	localparam logic [16:0] UNITY = 17'd65536;

	localparam logic [2:0] REQ_TICK  = 3'd0;
	localparam logic [2:0] REQ_START = 3'd1;
	localparam logic [2:0] REQ_VOL   = 3'd2;
	localparam logic [2:0] REQ_PITCH = 3'd3;
	localparam logic [2:0] REQ_WRITE = 3'd4;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NO_VOICE = 2'd1;
	localparam logic [1:0] ST_INACTIVE = 2'd2;

	localparam logic CFG_MASTER_LEFT  = 1'b0;
	localparam logic CFG_MASTER_RIGHT = 1'b1;

	// Per-voice record held in the voice memory.
	typedef struct packed {
		logic [15:0] start;
		logic [15:0] length;
		logic [31:0] position;
		logic [17:0] pitch;
		logic [24:0] vol_l;
		logic [24:0] vol_r;
		logic [16:0] tgt_l;
		logic [16:0] tgt_r;
		logic [25:0] ramp_l;
		logic [25:0] ramp_r;
	} voice_rec_t;

	// Request from the sequencer to the fade divider.
	typedef struct packed {
		logic        go;
		logic [24:0] mag;
		logic [19:0] frames;
	} div_req_t;

	function automatic logic [16:0] sat_gain(input logic [16:0] v);
		return (v > UNITY) ? UNITY : v;
	endfunction

endpackage

// ===== hdl/vmix_div.sv =====
// Restoring divider computing a ceiling quotient for fade ramps, one bit per cycle.
module vmix_div
	import vmix_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  div_req_t    req,
	output logic        done,
	output logic [24:0] quot
);

	logic [4:0]  cnt_q;
	logic        busy_q;
	logic [24:0] num_q;
	logic [20:0] rem_q;
	logic [19:0] den_q;
	logic [20:0] trial;

	assign trial = {rem_q[19:0], num_q[24]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (req.go) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd24) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.go) begin
			num_q <= req.mag;
			den_q <= req.frames;
			rem_q <= '0;
		end else if (busy_q) begin
			if (trial >= {1'b0, den_q}) begin
				rem_q <= trial - {1'b0, den_q};
				num_q <= {num_q[23:0], 1'b1};
			end else begin
				rem_q <= trial;
				num_q <= {num_q[23:0], 1'b0};
			end
		end
	end

	assign quot = num_q + {24'd0, (rem_q != '0)};

endmodule

// ===== hdl/vmix_mac.sv =====
// Interpolation and gain multiply-accumulate datapath with output rounding and saturation.
module vmix_mac
	import vmix_pkg::*;
(
	input  logic               clk,
	input  logic               clr,
	input  logic               en_interp,
	input  logic               en_acc,
	input  logic signed [15:0] s0,
	input  logic signed [15:0] s1,
	input  logic [15:0]        frac,
	input  logic [24:0]        vol_l,
	input  logic [24:0]        vol_r,
	input  logic [16:0]        m_left,
	input  logic [16:0]        m_right,
	output logic signed [15:0] left_out,
	output logic signed [15:0] right_out
);

	logic signed [33:0] p0_s1, p1_s1;
	logic [33:0]        gl_s1, gr_s1;
	logic signed [33:0] interp_s2;
	logic [16:0]        gl_s2, gr_s2;
	logic signed [51:0] acc_l_q, acc_r_q;
	logic signed [51:0] pl, pr;

	always_ff @(posedge clk) begin
		p0_s1 <= 34'(s0) * $signed({1'b0, 17'(UNITY - {1'b0, frac})});
		p1_s1 <= 34'(s1) * $signed({18'd0, frac});
		gl_s1 <= {17'd0, vol_l[24:8]} * {17'd0, m_left};
		gr_s1 <= {17'd0, vol_r[24:8]} * {17'd0, m_right};
		if (en_interp) begin
			interp_s2 <= p0_s1 + p1_s1;
			gl_s2     <= 17'((gl_s1 + 34'd32768) >> 16);
			gr_s2     <= 17'((gr_s1 + 34'd32768) >> 16);
		end
	end

	assign pl = 52'(interp_s2) * $signed({35'd0, gl_s2});
	assign pr = 52'(interp_s2) * $signed({35'd0, gr_s2});

	always_ff @(posedge clk) begin
		if (clr) begin
			acc_l_q <= '0;
			acc_r_q <= '0;
		end else if (en_acc) begin
			acc_l_q <= acc_l_q + pl;
			acc_r_q <= acc_r_q + pr;
		end
	end

	function automatic logic signed [15:0] to_frame(input logic signed [51:0] a);
		logic signed [51:0] b;
		logic signed [19:0] v;
		b = a + 52'sd2147483648;
		v = b[51:32];
		if (v > 20'sd32767)       return 16'sh7fff;
		else if (v < -20'sd32768) return 16'sh8000;
		else                      return v[15:0];
	endfunction

	assign left_out  = to_frame(acc_l_q);
	assign right_out = to_frame(acc_r_q);

endmodule

// ===== hdl/voice_mixer_with_resampling.sv =====
// Top level of the voice mixer: request sequencer, sample memory and voice memory.
// Each request is one input beat and yields one result beat, and requests are handled one at a
// time. A tick walks the busy voices one after another through the voice memory and the
// single-port sample memory, each voice passing the states TRD, TS0, TS1, TMUL, TACC and TWB.
// A volume request with a fade runs one 25-step ramp division for each side whose volume
// changes. The output register lets the next request be taken while a result waits. A request
// that completes while the previous result still waits holds until that result is taken.
module voice_mixer_with_resampling
	import vmix_pkg::*;
#(
	parameter int VOICES       = VOICES_DEF,
	parameter int SAMPLE_DEPTH = SAMPLE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         req_type,
	input  logic [15:0]        mem_addr,
	input  logic [15:0]        sound_length,
	input  logic signed [15:0] sample_word,
	input  logic [2:0]         voice,
	input  logic [16:0]        volume_left,
	input  logic [16:0]        volume_right,
	input  logic [19:0]        fade_frames,
	input  logic [17:0]        pitch_step,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [0:0]         cfg_index,
	input  logic [16:0]        cfg_data,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] left_sample,
	output logic signed [15:0] right_sample,
	output logic [2:0]         voice_assigned,
	output logic [1:0]         status,
	output logic [3:0]         active_count
);

	localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;
	localparam int AW = $clog2(SAMPLE_DEPTH);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_DEC   = 4'd1;
	localparam logic [3:0] S_TRD   = 4'd2;
	localparam logic [3:0] S_TS0   = 4'd3;
	localparam logic [3:0] S_TS1   = 4'd4;
	localparam logic [3:0] S_TMUL  = 4'd5;
	localparam logic [3:0] S_TACC  = 4'd6;
	localparam logic [3:0] S_TWB   = 4'd7;
	localparam logic [3:0] S_VRD   = 4'd8;
	localparam logic [3:0] S_VDL   = 4'd9;
	localparam logic [3:0] S_VDR   = 4'd10;
	localparam logic [3:0] S_VWB   = 4'd11;
	localparam logic [3:0] S_PRD   = 4'd12;
	localparam logic [3:0] S_DONE  = 4'd13;

	logic [3:0]  state_q;
	logic [VOICES-1:0] busy_q;
	logic [16:0] m_left_q, m_right_q;

	logic [2:0]  req_q;
	logic [15:0] addr_q, len_q;
	logic [15:0] word_q;
	logic [2:0]  voice_q;
	logic [16:0] vl_q, vr_q;
	logic [19:0] frames_q;
	logic [17:0] pitch_q;

	logic [15:0] smem [SAMPLE_DEPTH];
	logic [15:0] srd_q;
	logic        s_we;
	logic [AW-1:0] s_addr;

	voice_rec_t vmem [VOICES];
	voice_rec_t vrd_q, rec_q;
	logic       v_we;
	logic [VW-1:0] v_addr, idx_q;
	voice_rec_t v_wdata;

	logic [15:0] s0_q;
	logic [1:0]  status_q;
	logic [2:0]  assigned_q;

	div_req_t    dreq;
	logic        ddone;
	logic [24:0] dquot;
	logic        dpend_q, dside_q;

	logic        mac_clr, mac_int, mac_acc;
	logic signed [15:0] mix_l, mix_r;

	logic        free_found;
	logic [VW-1:0] free_idx;
	logic [31:0] base;
	logic        bad_voice;

	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = VOICES - 1; i >= 0; i--) begin
			if (!busy_q[i]) begin
				free_found = 1'b1;
				free_idx   = VW'(i);
			end
		end
	end

	assign bad_voice = (int'(voice_q) >= VOICES) || !busy_q[VW'(voice_q)];

	assign in_ready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;

	// Sample memory.
	assign base = (state_q == S_TS0) ?
		{16'd0, vrd_q.start} + {16'd0, vrd_q.position[31:16]} :
		{16'd0, rec_q.start} + {16'd0, rec_q.position[31:16]};

	always_comb begin
		s_we   = 1'b0;
		s_addr = AW'(addr_q);
		if (state_q == S_DEC && req_q == REQ_WRITE) s_we = 1'b1;
		else if (state_q == S_TS0) s_addr = AW'(base);
		else if (state_q == S_TS1) s_addr = AW'(base + 32'd1);
	end

	always_ff @(posedge clk) begin
		if (s_we) smem[s_addr] <= word_q;
		srd_q <= smem[s_addr];
	end

	always_ff @(posedge clk) begin
		if (v_we) vmem[v_addr] <= v_wdata;
		vrd_q <= vmem[v_addr];
	end

	// Volume step for a tick.
	function automatic void step_vol(input logic [24:0] vol, input logic [16:0] tgt,
		input logic [25:0] ramp, output logic [24:0] nvol, output logic [25:0] nramp);
		logic signed [26:0] nv;
		logic signed [26:0] t;
		nv = $signed({2'b00, vol}) + 27'($signed(ramp));
		t  = $signed({2'b00, tgt, 8'd0});
		nvol  = vol;
		nramp = ramp;
		if (ramp != '0) begin
			if ((!ramp[25] && nv >= t) || (ramp[25] && nv <= t)) begin
				nvol  = {tgt, 8'd0};
				nramp = '0;
			end else begin
				nvol = nv[24:0];
			end
		end
	endfunction

	voice_rec_t tick_rec;
	logic [31:0] npos;
	always_comb begin
		tick_rec = rec_q;
		step_vol(rec_q.vol_l, rec_q.tgt_l, rec_q.ramp_l, tick_rec.vol_l, tick_rec.ramp_l);
		step_vol(rec_q.vol_r, rec_q.tgt_r, rec_q.ramp_r, tick_rec.vol_r, tick_rec.ramp_r);
		npos = rec_q.position + {14'd0, rec_q.pitch};
		tick_rec.position = npos;
	end

	voice_rec_t start_rec;
	always_comb begin
		start_rec.start    = addr_q;
		start_rec.length   = len_q;
		start_rec.position = '0;
		start_rec.pitch    = {1'b0, UNITY};
		start_rec.vol_l    = {UNITY, 8'd0};
		start_rec.vol_r    = {UNITY, 8'd0};
		start_rec.tgt_l    = UNITY;
		start_rec.tgt_r    = UNITY;
		start_rec.ramp_l   = '0;
		start_rec.ramp_r   = '0;
	end

	voice_rec_t pitch_rec;
	always_comb begin
		pitch_rec       = vrd_q;
		pitch_rec.pitch = pitch_q;
	end

	// Fade set-up for one side.
	logic [16:0] tgt_side;
	logic [24:0] cur_side;
	logic signed [26:0] delta;
	logic [24:0] dmag;
	assign tgt_side = sat_gain(dside_q ? vr_q : vl_q);
	assign cur_side = dside_q ? rec_q.vol_r : rec_q.vol_l;
	assign delta = $signed({2'b00, tgt_side, 8'd0}) - $signed({2'b00, cur_side});
	assign dmag  = delta[26] ? 25'(-delta) : delta[24:0];

	always_comb begin
		v_we    = 1'b0;
		v_addr  = idx_q;
		v_wdata = rec_q;
		if (state_q == S_DEC && req_q == REQ_START) begin
			v_we    = free_found;
			v_addr  = free_idx;
			v_wdata = start_rec;
		end else if (state_q == S_DEC && (req_q == REQ_VOL || req_q == REQ_PITCH)) begin
			v_addr = VW'(voice_q);
		end else if (state_q == S_TWB || state_q == S_VWB) begin
			v_we = 1'b1;
			v_wdata = (state_q == S_TWB) ? tick_rec : rec_q;
		end else if (state_q == S_PRD) begin
			v_we    = 1'b1;
			v_wdata = pitch_rec;
		end
	end

	assign dreq.go     = (state_q == S_VDL || state_q == S_VDR) && !dpend_q && frames_q != '0
		&& delta != '0;
	assign dreq.mag    = dmag;
	assign dreq.frames = frames_q;

	vmix_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.done   (ddone),
		.quot   (dquot)
	);

	assign mac_clr = (state_q == S_DEC);
	assign mac_int = (state_q == S_TACC);
	assign mac_acc = (state_q == S_TWB);

	vmix_mac u_mac (
		.clk       (clk),
		.clr       (mac_clr),
		.en_interp (mac_int),
		.en_acc    (mac_acc),
		.s0        ($signed(s0_q)),
		.s1        ($signed(srd_q)),
		.frac      (rec_q.position[15:0]),
		.vol_l     (rec_q.vol_l),
		.vol_r     (rec_q.vol_r),
		.m_left    (m_left_q),
		.m_right   (m_right_q),
		.left_out  (mix_l),
		.right_out (mix_r)
	);

	// Next busy voice at or after a given slot.
	function automatic logic [VW:0] next_busy(input logic [VOICES-1:0] b, input int from);
		logic [VW:0] r;
		r = VOICES[VW:0];
		for (int i = VOICES - 1; i >= 0; i--)
			if (b[i] && i >= from) r = (VW+1)'(i);
		return r;
	endfunction

	logic [VW:0] nb_first, nb_next;
	assign nb_first = next_busy(busy_q, 0);
	assign nb_next  = next_busy(busy_q, int'(idx_q) + 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			busy_q    <= '0;
			m_left_q  <= UNITY;
			m_right_q <= UNITY;
			out_valid <= 1'b0;
			dpend_q   <= 1'b0;
			dside_q   <= 1'b0;
			idx_q     <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_MASTER_LEFT) m_left_q  <= sat_gain(cfg_data);
				else                              m_right_q <= sat_gain(cfg_data);
			end
			if (out_valid && out_ready && state_q != S_DONE) out_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid && in_ready) state_q <= S_DEC;
				end
				S_DEC: begin
					unique case (req_q)
						REQ_TICK: begin
							if (nb_first == VOICES[VW:0]) state_q <= S_DONE;
							else begin
								idx_q   <= VW'(nb_first);
								state_q <= S_TRD;
							end
						end
						REQ_START: begin
							if (free_found) busy_q[free_idx] <= 1'b1;
							state_q <= S_DONE;
						end
						REQ_VOL, REQ_PITCH: begin
							idx_q <= VW'(voice_q);
							if (bad_voice)
								state_q <= S_DONE;
							else state_q <= (req_q == REQ_VOL) ? S_VRD : S_PRD;
						end
						default: state_q <= S_DONE;
					endcase
				end
				S_TRD:  state_q <= S_TS0;
				S_TS0:  state_q <= S_TS1;
				S_TS1:  state_q <= S_TMUL;
				S_TMUL: state_q <= S_TACC;
				S_TACC: state_q <= S_TWB;
				S_TWB: begin
					if (npos[31:16] >= rec_q.length) busy_q[idx_q] <= 1'b0;
					if (nb_next == VOICES[VW:0]) state_q <= S_DONE;
					else begin
						idx_q   <= VW'(nb_next);
						state_q <= S_TRD;
					end
				end
				S_VRD: begin
					dside_q <= 1'b0;
					state_q <= S_VDL;
				end
				S_VDL, S_VDR: begin
					if (!dpend_q && dreq.go) dpend_q <= 1'b1;
					else if (!dpend_q || ddone) begin
						dpend_q <= 1'b0;
						dside_q <= 1'b1;
						state_q <= (state_q == S_VDL) ? S_VDR : S_VWB;
					end
				end
				S_VWB:  state_q <= S_DONE;
				S_PRD:  state_q <= S_DONE;
				S_DONE: begin
					if (!out_valid || out_ready) begin
						out_valid <= 1'b1;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_q    <= req_type;
			addr_q   <= mem_addr;
			len_q    <= sound_length;
			word_q   <= sample_word;
			voice_q  <= voice;
			vl_q     <= volume_left;
			vr_q     <= volume_right;
			frames_q <= fade_frames;
			pitch_q  <= pitch_step;
		end
		case (state_q)
			S_DEC: begin
				status_q   <= ST_OK;
				assigned_q <= '0;
				if (req_q == REQ_START) begin
					if (free_found) assigned_q <= 3'(free_idx);
					else            status_q   <= ST_NO_VOICE;
				end
				if ((req_q == REQ_VOL || req_q == REQ_PITCH) && bad_voice)
					status_q <= ST_INACTIVE;
			end
			S_TS0: rec_q <= vrd_q;
			S_TS1: s0_q  <= srd_q;
			S_VDL, S_VDR: begin
				if (!dpend_q && !dreq.go) begin
					if (dside_q) begin
						rec_q.tgt_r  <= tgt_side;
						rec_q.vol_r  <= {tgt_side, 8'd0};
						rec_q.ramp_r <= '0;
					end else begin
						rec_q.tgt_l  <= tgt_side;
						rec_q.vol_l  <= {tgt_side, 8'd0};
						rec_q.ramp_l <= '0;
					end
				end else if (dpend_q && ddone) begin
					if (dside_q) begin
						rec_q.tgt_r  <= tgt_side;
						rec_q.ramp_r <= delta[26] ? 26'(-{1'b0, dquot}) : {1'b0, dquot};
					end else begin
						rec_q.tgt_l  <= tgt_side;
						rec_q.ramp_l <= delta[26] ? 26'(-{1'b0, dquot}) : {1'b0, dquot};
					end
				end
			end
			S_VRD: rec_q <= vrd_q;
			S_PRD: ;
			default: ;
		endcase
		if (state_q == S_DONE && (!out_valid || out_ready)) begin
			left_sample    <= (req_q == REQ_TICK) ? mix_l : 16'sd0;
			right_sample   <= (req_q == REQ_TICK) ? mix_r : 16'sd0;
			voice_assigned <= assigned_q;
			status         <= status_q;
			active_count   <= 4'($countones(busy_q));
		end
	end

endmodule

// ===== hdl/vmix_checker.sv =====
// Port-level checker for the voice mixer, bound to the top level.
module vmix_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] status,
	input logic [3:0] active_count,
	input logic [2:0] voice_assigned
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status))
		else $error("result beat dropped while stalled");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status != 2'd3)
		else $error("status code out of range");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> active_count <= 4'd8)
		else $error("active count out of range");

	a_nofail_assign: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != 2'd0 |-> voice_assigned == 3'd0)
		else $error("slot reported on a failed request");

endmodule

bind voice_mixer_with_resampling vmix_checker u_vmix_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_ready       (in_ready),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.status         (status),
	.active_count   (active_count),
	.voice_assigned (voice_assigned)
);
